[rtl/gspd_pkg.sv]
// Package for the gain-scheduled PD heater core.
// Holds widths, controller constants, register indexes and the shared result type.
// No dependencies.
package gspd_pkg;

   localparam int TEMP_W  = 10;
   localparam int VOLTS_W = 8;
   localparam int ERR_W   = 12;
   localparam int CTRL_W  = 22;
   localparam int DUTY_W  = 8;
   localparam int GAIN_W  = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SETPOINT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SUPPLY_VOLTS = 2'd1;

   localparam logic [TEMP_W-1:0]  MAX_SETPOINT_RESET     = 10'd480;
   localparam logic [VOLTS_W-1:0] MIN_SUPPLY_VOLTS_RESET = 8'd0;
   localparam logic [TEMP_W-1:0]  LOW_SETPOINT_LIMIT     = 10'd50;

   localparam logic signed [TEMP_W:0] ERR_STEP_4 = 11'sd40;
   localparam logic signed [TEMP_W:0] ERR_STEP_3 = 11'sd30;
   localparam logic signed [TEMP_W:0] ERR_STEP_2 = 11'sd20;
   localparam logic signed [TEMP_W:0] ERR_STEP_1 = 11'sd10;

   localparam logic [GAIN_W-1:0] GAIN_4 = 10'd650;
   localparam logic [GAIN_W-1:0] GAIN_3 = 10'd550;
   localparam logic [GAIN_W-1:0] GAIN_2 = 10'd400;
   localparam logic [GAIN_W-1:0] GAIN_1 = 10'd250;
   localparam logic [GAIN_W-1:0] GAIN_0 = 10'd100;

   localparam logic signed [CTRL_W-1:0] DUTY_MAX_HUNDREDTHS = 22'sd25500;
   localparam logic [DUTY_W-1:0]        DUTY_FULL           = 8'd255;

   // Dividing by 100 is a multiply by 5243 and a right shift by 19; exact up to 25500.
   localparam int QUO_IN_W  = 15;
   localparam int RECIP_W   = 13;
   localparam int RECIP_SH  = 19;
   localparam int SCALED_W  = 27;
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

   typedef struct packed {
      logic [ERR_W-1:0]  error;
      logic [CTRL_W-1:0] ctrl;
   } law_result_type;

endpackage

[rtl/gspd_law.sv]
// Control law of the heater core: error, scheduled gain and derivative term.
// Purely combinational; depends on gspd_pkg.
module gspd_law (
   input  logic [gspd_pkg::TEMP_W-1:0] setpoint,
   input  logic [gspd_pkg::TEMP_W-1:0] measured,
   input  logic [gspd_pkg::ERR_W-1:0]  prev_error,
   output gspd_pkg::law_result_type    result
);
   import gspd_pkg::*;

   logic signed [TEMP_W:0]   err;
   logic [GAIN_W-1:0]        gain;
   logic signed [CTRL_W-1:0] prop;
   logic signed [ERR_W-1:0]  diff;

   assign err = $signed({1'b0, setpoint}) - $signed({1'b0, measured});

   always_comb begin
      if (err > ERR_STEP_4) begin
         gain = GAIN_4;
      end else if (err > ERR_STEP_3) begin
         gain = GAIN_3;
      end else if (err > ERR_STEP_2) begin
         gain = GAIN_2;
      end else if (err > ERR_STEP_1) begin
         gain = GAIN_1;
      end else begin
         gain = GAIN_0;
      end
   end

   assign prop = $signed({1'b0, gain}) * err;
   assign diff = $signed({err[TEMP_W], err}) - $signed(prev_error);

   assign result.error = {err[TEMP_W], err};
   assign result.ctrl  = prop + {{(CTRL_W-ERR_W){diff[ERR_W-1]}}, diff};

endmodule

[rtl/gspd_duty.sv]
// Output stage of the heater core: enable decision, saturation and hundredths to duty.
// Purely combinational; depends on gspd_pkg.
module gspd_duty (
   input  logic [gspd_pkg::CTRL_W-1:0] ctrl,
   input  logic                        allowed,
   output logic                        heater_on,
   output logic [gspd_pkg::DUTY_W-1:0] duty
);
   import gspd_pkg::*;

   logic                positive;
   logic                saturate;
   logic [SCALED_W-1:0] scaled;

   assign positive  = !ctrl[CTRL_W-1] && (ctrl != '0);
   assign saturate  = $signed(ctrl) > DUTY_MAX_HUNDREDTHS;
   assign scaled    = SCALED_W'(ctrl[QUO_IN_W-1:0]) * SCALED_W'(RECIP_100);
   assign heater_on = allowed && positive;

   always_comb begin
      if (!heater_on) begin
         duty = '0;
      end else if (saturate) begin
         duty = DUTY_FULL;
      end else begin
         duty = scaled[RECIP_SH+DUTY_W-1:RECIP_SH];
      end
   end

endmodule

[rtl/gain_scheduled_pd_heater_core.sv]
// Top level of the gain-scheduled PD heater controller.
// Depends on gspd_pkg, gspd_law and gspd_duty.
//
//   channel | ports                                  | direction
//   req     | req_valid/ready, setpoint, measured,   | in
//           | supply_volts                           |
//   rsp     | rsp_valid/ready, heater_on, duty       | out
//   csr     | csr_valid/ready, csr_index, csr_data   | in
//
// Three register stages: input, control value, result. One item per cycle while rsp is not stalled;
// an accepted item passes through the input, control value and result registers in order.
// A stall on rsp holds every stage; req_ready follows the result register.
// Reset clears the stage valid bits and the previous error and loads both registers with their reset values.
// Register writes are always taken; csr_ready is tied high.
module gain_scheduled_pd_heater_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [gspd_pkg::TEMP_W-1:0]     req_setpoint,
   input  logic [gspd_pkg::TEMP_W-1:0]     req_measured,
   input  logic [gspd_pkg::VOLTS_W-1:0]    req_supply_volts,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_heater_on,
   output logic [gspd_pkg::DUTY_W-1:0]     rsp_duty,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gspd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gspd_pkg::CSR_DATA_W-1:0] csr_data
);
   import gspd_pkg::*;

   logic                advance;
   law_result_type      law;
   logic                out_on;
   logic [DUTY_W-1:0]   out_duty;

   logic [TEMP_W-1:0]   max_setpoint_ff, max_setpoint_in;
   logic [VOLTS_W-1:0]  min_volts_ff, min_volts_in;
   logic [ERR_W-1:0]    prev_error_ff, prev_error_in;

   logic                s1_valid_ff, s1_valid_in;
   logic [TEMP_W-1:0]   s1_setpoint_ff, s1_setpoint_in;
   logic [TEMP_W-1:0]   s1_measured_ff, s1_measured_in;
   logic [VOLTS_W-1:0]  s1_volts_ff, s1_volts_in;

   logic                s2_valid_ff, s2_valid_in;
   logic [CTRL_W-1:0]   s2_ctrl_ff, s2_ctrl_in;
   logic                s2_allowed_ff, s2_allowed_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_on_ff, rsp_on_in;
   logic [DUTY_W-1:0]   rsp_duty_ff, rsp_duty_in;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_heater_on = rsp_on_ff;
   assign rsp_duty      = rsp_duty_ff;

   gspd_law u_law (
      .setpoint   (s1_setpoint_ff),
      .measured   (s1_measured_ff),
      .prev_error (prev_error_ff),
      .result     (law)
   );

   gspd_duty u_duty (
      .ctrl      (s2_ctrl_ff),
      .allowed   (s2_allowed_ff),
      .heater_on (out_on),
      .duty      (out_duty)
   );

   always_comb begin
      max_setpoint_in = max_setpoint_ff;
      min_volts_in    = min_volts_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MAX_SETPOINT:     max_setpoint_in = csr_data[TEMP_W-1:0];
            CSR_MIN_SUPPLY_VOLTS: min_volts_in    = csr_data[VOLTS_W-1:0];
            default:              ;
         endcase
      end
   end

   always_comb begin
      s1_valid_in    = s1_valid_ff;
      s1_setpoint_in = s1_setpoint_ff;
      s1_measured_in = s1_measured_ff;
      s1_volts_in    = s1_volts_ff;
      s2_valid_in    = s2_valid_ff;
      s2_ctrl_in     = s2_ctrl_ff;
      s2_allowed_in  = s2_allowed_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_on_in      = rsp_on_ff;
      rsp_duty_in    = rsp_duty_ff;
      prev_error_in  = prev_error_ff;
      if (advance) begin
         s1_valid_in    = req_valid;
         s1_setpoint_in = req_setpoint;
         s1_measured_in = req_measured;
         s1_volts_in    = req_supply_volts;
         s2_valid_in    = s1_valid_ff;
         s2_ctrl_in     = law.ctrl;
         s2_allowed_in  = (s1_setpoint_ff > LOW_SETPOINT_LIMIT) &&
                          (s1_setpoint_ff <= max_setpoint_ff) &&
                          (s1_volts_ff >= min_volts_ff);
         rsp_valid_in   = s2_valid_ff;
         rsp_on_in      = out_on;
         rsp_duty_in    = out_duty;
         if (s1_valid_ff) begin
            prev_error_in = law.error;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_setpoint_ff <= MAX_SETPOINT_RESET;
         min_volts_ff    <= MIN_SUPPLY_VOLTS_RESET;
         prev_error_ff   <= '0;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         max_setpoint_ff <= max_setpoint_in;
         min_volts_ff    <= min_volts_in;
         prev_error_ff   <= prev_error_in;
         s1_valid_ff     <= s1_valid_in;
         s2_valid_ff     <= s2_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_setpoint_ff <= s1_setpoint_in;
      s1_measured_ff <= s1_measured_in;
      s1_volts_ff    <= s1_volts_in;
      s2_ctrl_ff     <= s2_ctrl_in;
      s2_allowed_ff  <= s2_allowed_in;
      rsp_on_ff      <= rsp_on_in;
      rsp_duty_ff    <= rsp_duty_in;
   end

`ifndef ASSERT_OFF
   a_off_means_zero_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_on_ff |-> rsp_duty_ff == '0)
      else $error("heater off with nonzero duty");

   a_prev_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(prev_error_ff))
      else $error("previous error moved during a stall");

   a_stall_holds_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_duty_ff) &&
      $stable(rsp_on_ff))
      else $error("result changed while stalled");

   a_prev_tracks_item: assert property (@(posedge clock) disable iff (reset)
      advance && s1_valid_ff |=> prev_error_ff == $past(law.error))
      else $error("previous error not updated by item");

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid_ff && !s1_valid_ff && !s2_valid_ff)
      else $error("pipeline not empty after reset");
`endif

endmodule

[bench/gain_scheduled_pd_heater_core_tb.sv]
// Self-checking testbench for gain_scheduled_pd_heater_core.
// Depends on gspd_pkg and the core; runs directed and random control ticks with
// random idling and back-pressure, and checks every result against its own predictor.
module gain_scheduled_pd_heater_core_tb;
   import gspd_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      logic              heater_on;
      logic [DUTY_W-1:0] duty;
   } heater_drive_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [TEMP_W-1:0]     req_setpoint = '0;
   logic [TEMP_W-1:0]     req_measured = '0;
   logic [VOLTS_W-1:0]    req_supply_volts = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_heater_on;
   logic [DUTY_W-1:0]     rsp_duty;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   logic [TEMP_W-1:0]       max_setpoint_cfg = MAX_SETPOINT_RESET;
   logic [VOLTS_W-1:0]      min_volts_cfg    = MIN_SUPPLY_VOLTS_RESET;
   logic signed [ERR_W-1:0] last_error       = '0;

   heater_drive_type drive_expected_q[$];
   int  send_idle_pct   = 0;
   int  recv_stall_pct  = 0;
   logic rsp_hold       = 1'b0;
   int  items_sent      = 0;
   int  drives_checked  = 0;
   int  drives_enabled  = 0;
   int  reg_writes      = 0;
   int  mismatch_count  = 0;

   gain_scheduled_pd_heater_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_setpoint     (req_setpoint),
      .req_measured     (req_measured),
      .req_supply_volts (req_supply_volts),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_heater_on    (rsp_heater_on),
      .rsp_duty         (rsp_duty),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic heater_drive_type compute_drive(input logic [TEMP_W-1:0] sp,
                                                      input logic [TEMP_W-1:0] meas,
                                                      input logic [VOLTS_W-1:0] volts);
      heater_drive_type drive;
      int   err;
      int   gain;
      int   ctrl;
      logic allowed;
      err = int'(sp) - int'(meas);
      if (err > int'(ERR_STEP_4)) gain = int'(GAIN_4);
      else if (err > int'(ERR_STEP_3)) gain = int'(GAIN_3);
      else if (err > int'(ERR_STEP_2)) gain = int'(GAIN_2);
      else if (err > int'(ERR_STEP_1)) gain = int'(GAIN_1);
      else gain = int'(GAIN_0);
      ctrl = gain * err + (err - int'(last_error));
      allowed = (sp > LOW_SETPOINT_LIMIT) && (sp <= max_setpoint_cfg) &&
                (volts >= min_volts_cfg);
      drive.heater_on = 1'b0;
      drive.duty = '0;
      if (allowed && ctrl > 0) begin
         drive.heater_on = 1'b1;
         drive.duty = (ctrl > int'(DUTY_MAX_HUNDREDTHS)) ? DUTY_FULL : DUTY_W'(ctrl / 100);
      end
      last_error = ERR_W'(err);
      return drive;
   endfunction

   task automatic send_item(input logic [TEMP_W-1:0] sp, input logic [TEMP_W-1:0] meas,
                            input logic [VOLTS_W-1:0] volts);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_setpoint     <= sp;
      req_measured     <= meas;
      req_supply_volts <= volts;
      do @(posedge clock); while (!req_ready);
      drive_expected_q.push_back(compute_drive(sp, meas, volts));
      items_sent++;
   endtask

   task automatic send_random_item();
      int sp;
      int meas;
      int delta;
      int volts;
      if ($urandom_range(99) < 75 && max_setpoint_cfg > LOW_SETPOINT_LIMIT) begin
         sp = $urandom_range(int'(max_setpoint_cfg), int'(LOW_SETPOINT_LIMIT) + 1);
         if ($urandom_range(99) < 80) delta = int'($urandom_range(120)) - 60;
         else delta = int'($urandom_range(1023)) - 511;
         meas = sp - delta;
         if (meas < 0) meas = 0;
         if (meas > 1023) meas = 1023;
         volts = $urandom_range(255, int'(min_volts_cfg));
      end else begin
         sp    = $urandom_range(1023);
         meas  = $urandom_range(1023);
         volts = $urandom_range(255);
      end
      send_item(TEMP_W'(sp), TEMP_W'(meas), VOLTS_W'(volts));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (drive_expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MAX_SETPOINT:     max_setpoint_cfg = data[TEMP_W-1:0];
         CSR_MIN_SUPPLY_VOLTS: min_volts_cfg = data[VOLTS_W-1:0];
         default: ;
      endcase
      reg_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin : result_check
      heater_drive_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (drive_expected_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result item: heater_on=%0d duty=%0d",
                        rsp_heater_on, rsp_duty);
         end else begin
            want = drive_expected_q.pop_front();
            drives_checked++;
            if (want.heater_on) drives_enabled++;
            if (rsp_heater_on !== want.heater_on || rsp_duty !== want.duty) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: heater_on exp %0d got %0d, duty exp %0d got %0d",
                           want.heater_on, rsp_heater_on, want.duty, rsp_duty);
            end
         end
      end
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic test_default_registers();
      send_item(10'd480, 10'd0, 8'd0);
      send_item(10'd481, 10'd0, 8'd255);
      send_item(10'd50, 10'd0, 8'd255);
      send_item(10'd51, 10'd51, 8'd128);
   endtask

   task automatic test_gain_bands();
      send_item(10'd200, 10'd159, 8'd24);
      send_item(10'd200, 10'd160, 8'd24);
      send_item(10'd200, 10'd169, 8'd24);
      send_item(10'd200, 10'd170, 8'd24);
      send_item(10'd200, 10'd179, 8'd24);
      send_item(10'd200, 10'd180, 8'd24);
      send_item(10'd200, 10'd189, 8'd24);
      send_item(10'd200, 10'd190, 8'd24);
      send_item(10'd100, 10'd150, 8'd24);
      send_item(10'd100, 10'd100, 8'd24);
      send_item(10'd300, 10'd100, 8'd24);
      send_item(10'd100, 10'd99, 8'd24);
   endtask

   task automatic test_register_limits();
      wait_for_results();
      write_register(CSR_MAX_SETPOINT, 10'd1023);
      write_register(CSR_MIN_SUPPLY_VOLTS, 10'h3C8);
      write_register(CSR_SPARE_2, 10'd0);
      write_register(CSR_SPARE_3, 10'h3FF);
      send_item(10'd0, 10'd1023, 8'd255);
      send_item(10'd1023, 10'd0, 8'd200);
      send_item(10'd1023, 10'd0, 8'd199);
      wait_for_results();
      write_register(CSR_MAX_SETPOINT, 10'd0);
      write_register(CSR_MIN_SUPPLY_VOLTS, 10'd255);
      send_item(10'd51, 10'd0, 8'd255);
      send_item(10'd0, 10'd0, 8'd255);
   endtask

   task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                      input int n_items);
      send_idle_pct  = sender_idle;
      recv_stall_pct = receiver_stall;
      for (int chunk = 0; chunk < 4; chunk++) begin
         wait_for_results();
         case (chunk)
            0: begin
               write_register(CSR_MAX_SETPOINT, 10'd1023);
               write_register(CSR_MIN_SUPPLY_VOLTS, 10'd0);
            end
            1: begin
               write_register(CSR_MAX_SETPOINT, CSR_DATA_W'($urandom_range(1023, 51)));
               write_register(CSR_MIN_SUPPLY_VOLTS, CSR_DATA_W'($urandom_range(200)));
            end
            2: begin
               write_register(CSR_MAX_SETPOINT, CSR_DATA_W'($urandom_range(1023, 51)));
               write_register(CSR_MIN_SUPPLY_VOLTS, 10'd255);
            end
            default: begin
               write_register(CSR_MAX_SETPOINT, CSR_DATA_W'($urandom_range(1023)));
               write_register(CSR_MIN_SUPPLY_VOLTS, CSR_DATA_W'($urandom_range(1023)));
            end
         endcase
         for (int i = 0; i < n_items / 4; i++) send_random_item();
      end
   endtask

   task automatic test_output_backpressure();
      wait_for_results();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_register(CSR_MAX_SETPOINT, 10'd700);
      write_register(CSR_MIN_SUPPLY_VOLTS, 10'd12);
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (80) @(posedge clock);
            rsp_hold <= 1'b0;
         end
         begin
            for (int i = 0; i < 40; i++) send_random_item();
         end
      join
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_default_registers();
      test_gain_bands();
      test_register_limits();
      test_random_traffic(26, 52, 440);
      test_random_traffic(52, 26, 440);
      test_random_traffic(0, 0, 440);
      test_output_backpressure();
      wait_for_results();
      repeat (10) @(posedge clock);
      $display("Sent %0d control ticks and checked %0d results, %0d with the heater on.",
               items_sent, drives_checked, drives_enabled);
      $display("Made %0d register writes; %0d mismatches.", reg_writes, mismatch_count);
      if (mismatch_count == 0 && drive_expected_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Timed out waiting on the core.");
      $display("Some tests failed");
      $finish;
   end

endmodule
